// ----- sv/jcse_pkg.sv -----
// Shared types and constants for the JTAG command shift engine.
package jcse_pkg;

  // command parser phases
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_MODE   = 4'd1,
    PH_FEAT1  = 4'd2,
    PH_FEAT2  = 4'd3,
    PH_DLY_HI = 4'd4,
    PH_DLY_LO = 4'd5,
    PH_SPD    = 4'd6,
    PH_HS1    = 4'd7,
    PH_HS2    = 4'd8,
    PH_CNT_HI = 4'd9,
    PH_CNT_LO = 4'd10,
    PH_SHIFT  = 4'd11
  } phase_t;

  // host command bytes
  localparam logic [7:0] CMD_MODE    = 8'h01;
  localparam logic [7:0] CMD_FEAT    = 8'h02;
  localparam logic [7:0] CMD_SHIFT   = 8'h05;
  localparam logic [7:0] CMD_DELAY   = 8'h06;
  localparam logic [7:0] CMD_SPEED   = 8'h07;
  localparam logic [7:0] REPLY_UNKNOWN = 8'h00;

  // argument values that select driven pins and the fast link
  localparam logic [7:0] MODE_DRIVEN = 8'h01;
  localparam logic [7:0] SPEED_FAST  = 8'h01;

  // feature selectors
  localparam logic [7:0] FEAT_LED  = 8'h01;
  localparam logic [7:0] FEAT_VREG = 8'h02;
  localparam logic [7:0] FEAT_TRST = 8'h04;
  localparam logic [7:0] FEAT_SRST = 8'h08;
  localparam logic [7:0] FEAT_PULL = 8'h10;

  // speed handshake bytes
  localparam logic [7:0] HS_FIRST  = 8'hAA;
  localparam logic [7:0] HS_SECOND = 8'h55;

  // input kinds
  localparam logic OP_HOST = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // pin register bit positions
  localparam int unsigned PB_TCK   = 0;
  localparam int unsigned PB_TDI   = 1;
  localparam int unsigned PB_TMS   = 2;
  localparam int unsigned PB_TRST  = 3;
  localparam int unsigned PB_SRST  = 4;
  localparam int unsigned PB_LED   = 5;
  localparam int unsigned PB_VREG  = 6;
  localparam int unsigned PB_PULL  = 7;
  localparam int unsigned PB_DRIVE = 8;
  localparam int unsigned PB_FAST  = 9;
  localparam int unsigned PIN_W    = 10;

  // everything one input word produces
  typedef struct packed {
    logic [1:0]      cnt;     // result count, 1..3
    logic            txv;     // results carry reply bytes
    logic [2:0][7:0] bytes;   // reply bytes, entry 0 first
    logic [PIN_W-1:0] pins;   // pin levels after the word
  } bundle_t;

endpackage

// ----- sv/jcse_core.sv -----
// Command parser, bit shifter and pin registers; one word handled per cycle while fire is high.
module jcse_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              opcode,
  input  logic [7:0]        host_byte,
  input  logic              tdo_pin,
  output jcse_pkg::bundle_t bundle
);
  import jcse_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [7:0]        speed_r, speed_nxt;
  logic [15:0]       dly_r, dly_nxt;
  logic [15:0]       left_r, left_nxt;
  logic [15:0]       total_r, total_nxt;
  logic [15:0]       done_r, done_nxt;
  logic [7:0]        tdi_r, tdi_nxt;
  logic [7:0]        tms_r, tms_nxt;
  logic [1:0]        pair_r, pair_nxt;
  logic              low_r, low_nxt;
  logic [7:0]        tdo_r, tdo_nxt;
  logic [PIN_W-1:0]  pin_r, pin_nxt;

  logic [1:0]        n;
  logic [2:0][7:0]   tx;
  logic [2:0]        off;
  logic [15:0]       done_inc;
  logic [7:0]        tdo_word;
  logic [7:0]        new_speed;

  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    speed_nxt = speed_r;
    dly_nxt   = dly_r;
    left_nxt  = left_r;
    total_nxt = total_r;
    done_nxt  = done_r;
    tdi_nxt   = tdi_r;
    tms_nxt   = tms_r;
    pair_nxt  = pair_r;
    low_nxt   = low_r;
    tdo_nxt   = tdo_r;
    pin_nxt   = pin_r;
    n         = 2'd0;
    tx        = '0;
    off       = done_r[2:0];
    done_inc  = done_r + 16'd1;
    tdo_word  = tdo_r;
    tdo_word[off] = tdo_r[off] | tdo_pin;
    new_speed = speed_r;

    if (fire && opcode == OP_HOST) begin
      // host byte: advance the command parser
      unique case (phase_r)
        PH_IDLE: begin
          unique case (host_byte)
            CMD_MODE:    phase_nxt = PH_MODE;
            CMD_FEAT:    phase_nxt = PH_FEAT1;
            CMD_SHIFT:   phase_nxt = PH_CNT_HI;
            CMD_DELAY:   phase_nxt = PH_DLY_HI;
            CMD_SPEED:   phase_nxt = PH_SPD;
            default: begin
              tx[0] = REPLY_UNKNOWN;
              n     = 2'd1;
            end
          endcase
        end
        PH_MODE: begin
          pin_nxt[PB_TCK]   = 1'b0;
          pin_nxt[PB_TDI]   = 1'b0;
          pin_nxt[PB_TMS]   = 1'b0;
          pin_nxt[PB_TRST]  = 1'b0;
          pin_nxt[PB_SRST]  = 1'b0;
          pin_nxt[PB_DRIVE] = (host_byte == MODE_DRIVEN);
          phase_nxt = PH_IDLE;
        end
        PH_FEAT1, PH_DLY_HI, PH_HS1, PH_CNT_HI: begin
          first_nxt = host_byte;
          unique case (phase_r)
            PH_FEAT1:  phase_nxt = PH_FEAT2;
            PH_DLY_HI: phase_nxt = PH_DLY_LO;
            PH_HS1:    phase_nxt = PH_HS2;
            default:   phase_nxt = PH_CNT_LO;
          endcase
        end
        PH_FEAT2: begin
          unique case (first_r)
            FEAT_LED:  pin_nxt[PB_LED]  = host_byte[0];
            FEAT_VREG: pin_nxt[PB_VREG] = (host_byte != 8'h00);
            FEAT_TRST: pin_nxt[PB_TRST] = host_byte[0];
            FEAT_SRST: pin_nxt[PB_SRST] = host_byte[0];
            FEAT_PULL: pin_nxt[PB_PULL] = (host_byte != 8'h00);
            default: ;
          endcase
          phase_nxt = PH_IDLE;
        end
        PH_DLY_LO: begin
          dly_nxt   = {first_r, host_byte};
          phase_nxt = PH_IDLE;
        end
        PH_SPD: begin
          speed_nxt        = host_byte;
          pin_nxt[PB_FAST] = (host_byte == SPEED_FAST);
          phase_nxt        = PH_HS1;
        end
        PH_HS2: begin
          // failed handshake drops back to slow speed
          if (first_r != HS_FIRST || host_byte != HS_SECOND) begin
            new_speed        = 8'h00;
            pin_nxt[PB_FAST] = 1'b0;
          end
          speed_nxt = new_speed;
          tx[0]     = CMD_SPEED;
          tx[1]     = new_speed;
          n         = 2'd2;
          phase_nxt = PH_IDLE;
        end
        PH_CNT_LO: begin
          total_nxt = {first_r, host_byte};
          tx[0]     = CMD_SHIFT;
          tx[1]     = first_r;
          tx[2]     = host_byte;
          n         = 2'd3;
          done_nxt  = '0;
          pair_nxt  = 2'd0;
          low_nxt   = 1'b0;
          left_nxt  = '0;
          tdo_nxt   = '0;
          phase_nxt = ({first_r, host_byte} == 16'd0) ? PH_IDLE : PH_SHIFT;
        end
        PH_SHIFT: begin
          // collect the TDI then TMS byte; extra bytes are dropped
          if (pair_r == 2'd0) begin
            tdi_nxt  = host_byte;
            pair_nxt = 2'd1;
          end else if (pair_r == 2'd1) begin
            tms_nxt  = host_byte;
            pair_nxt = 2'd2;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end else if (fire && phase_r == PH_SHIFT && pair_r == 2'd2 && done_r < total_r) begin
      // tick: one step of the bit timing
      if (!low_r) begin
        pin_nxt[PB_TDI] = tdi_r[off];
        pin_nxt[PB_TMS] = tms_r[off];
        pin_nxt[PB_TCK] = 1'b0;
        left_nxt        = dly_r;
        low_nxt         = 1'b1;
      end else if (left_r != 16'd0) begin
        left_nxt = left_r - 16'd1;
      end else begin
        pin_nxt[PB_TCK] = 1'b1;
        low_nxt         = 1'b0;
        done_nxt        = done_inc;
        tdo_nxt         = tdo_word;
        if (off == 3'd7 || done_inc == total_r) begin
          tx[0]   = tdo_word;
          n       = 2'd1;
          tdo_nxt = '0;
        end
        if (off == 3'd7) pair_nxt = 2'd0;
        if (done_inc == total_r) begin
          pair_nxt  = 2'd0;
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  // result bundle for this word
  always_comb begin
    bundle.cnt   = (n == 2'd0) ? 2'd1 : n;
    bundle.txv   = (n != 2'd0);
    bundle.bytes = tx;
    bundle.pins  = pin_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      first_r <= '0;
      speed_r <= '0;
      dly_r   <= 16'd1;
      left_r  <= '0;
      total_r <= '0;
      done_r  <= '0;
      tdi_r   <= '0;
      tms_r   <= '0;
      pair_r  <= '0;
      low_r   <= 1'b0;
      tdo_r   <= '0;
      pin_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      speed_r <= speed_nxt;
      dly_r   <= dly_nxt;
      left_r  <= left_nxt;
      total_r <= total_nxt;
      done_r  <= done_nxt;
      tdi_r   <= tdi_nxt;
      tms_r   <= tms_nxt;
      pair_r  <= pair_nxt;
      low_r   <= low_nxt;
      tdo_r   <= tdo_nxt;
      pin_r   <= pin_nxt;
    end
  end

endmodule

// ----- sv/jtag_command_shift_engine_unit.sv -----
// Top level: JTAG command shift engine with a two-deep result queue.
// Each input word (a host byte or a timing tick with the TDO sample) is
// handled in the cycle it is accepted and gives one to three result words,
// which wait in a two-entry queue of result bundles. A word that gives one
// result sustains one word per clock while out_tready stays high; a word giving
// k results holds the output channel until all k are taken, so the rate is set
// by the output serializer when replies are being sent. in_tready drops only
// when both queue entries are occupied.
module jtag_command_shift_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] host_byte, [8] tdo_pin, rest zero
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] tx_byte, [8] tck_out, [9] tdi_out, [10] tms_out, [11] trst_out,
  // [12] srst_out, [13] led_out, [15:14] power_controls, [16] pins_driven,
  // [17] fast_serial, rest zero
  output logic [23:0] out_tdata,
  output logic        out_tuser,  // [0] tx_valid
  output logic        out_tlast   // last
);
  import jcse_pkg::*;

  bundle_t    bundle;
  bundle_t    q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] sub_r;
  logic       in_fire, out_fire, pop;
  bundle_t    head;
  logic [7:0] head_byte;

  assign in_tready = (count_r != 2'd2);
  assign in_fire   = in_tvalid && in_tready;

  jcse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .opcode    (in_tuser),
    .host_byte (in_tdata[7:0]),
    .tdo_pin   (in_tdata[8]),
    .bundle    (bundle)
  );

  // output serializer over the head bundle
  assign head       = q_r[rd_ptr_r];
  assign head_byte  = head.bytes[sub_r];
  assign out_tvalid = (count_r != 2'd0);
  assign out_tlast  = (sub_r == head.cnt - 2'd1);
  assign out_tuser  = head.txv;
  assign out_fire   = out_tvalid && out_tready;
  assign pop        = out_fire && out_tlast;

  assign out_tdata = {6'd0,
                      head.pins[PB_FAST], head.pins[PB_DRIVE],
                      head.pins[PB_PULL], head.pins[PB_VREG],
                      head.pins[PB_LED], head.pins[PB_SRST], head.pins[PB_TRST],
                      head.pins[PB_TMS], head.pins[PB_TDI], head.pins[PB_TCK],
                      head_byte};

  // queue payload
  always_ff @(posedge clk) begin
    if (in_fire) q_r[wr_ptr_r] <= bundle;
  end

  // queue pointers and serializer index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      sub_r    <= 2'd0;
    end else begin
      if (in_fire) wr_ptr_r <= ~wr_ptr_r;
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
        sub_r    <= 2'd0;
      end else if (out_fire) begin
        sub_r <= sub_r + 2'd1;
      end
      count_r <= count_r + {1'b0, in_fire} - {1'b0, pop};
    end
  end

endmodule

// ----- test/jtag_command_shift_engine_unit_tb.sv -----
// Self-checking testbench for the JTAG command shift engine: directed and random words.
module jtag_command_shift_engine_unit_tb;
  import jcse_pkg::*;

  localparam int          RAND_WORDS  = 240;
  localparam int          STRETCH     = RAND_WORDS / 4;
  localparam int          DRAIN_WAIT  = 20;

  // idling schemes, one per stretch of the random part
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // one expected result word
  typedef struct packed {
    logic             txv;
    logic [7:0]       txb;
    logic             lst;
    logic [PIN_W-1:0] pins;
  } reply_word_t;

  // directed stimulus row; pinned rows carry a hand-written reply
  typedef struct packed {
    logic       op;
    logic [7:0] b;
    logic       tdo;
    logic       pinned;
    logic       txv;
    logic [7:0] txb;
  } dir_row_t;

  dir_row_t directed_rows [0:25] = '{
    '{OP_HOST, 8'h03,         1'b0, 1'b1, 1'b1, REPLY_UNKNOWN},
    '{OP_HOST, 8'h00,         1'b1, 1'b1, 1'b1, REPLY_UNKNOWN},
    '{OP_HOST, 8'hFF,         1'b0, 1'b1, 1'b1, REPLY_UNKNOWN},
    '{OP_TICK, 8'hFF,         1'b1, 1'b1, 1'b0, 8'h00},
    '{OP_HOST, CMD_MODE,      1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, MODE_DRIVEN,   1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, CMD_FEAT,      1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, FEAT_LED,      1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, 8'hFF,         1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, CMD_FEAT,      1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, FEAT_VREG,     1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, 8'h80,         1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, CMD_SPEED,     1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, SPEED_FAST,    1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, HS_FIRST,      1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, HS_SECOND,     1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, CMD_SPEED,     1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, SPEED_FAST,    1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, 8'h00,         1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, HS_SECOND,     1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, CMD_DELAY,     1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, 8'h00,         1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, 8'h00,         1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, CMD_SHIFT,     1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, 8'h00,         1'b0, 1'b0, 1'b0, 8'h00},
    '{OP_HOST, 8'h00,         1'b0, 1'b0, 1'b0, 8'h00}
  };

  // engine mirror
  phase_t           cmd_ph;
  logic [7:0]       arg1;
  logic [7:0]       spd_arg;
  logic [15:0]      dly;
  logic [15:0]      dly_left;
  logic [15:0]      bits_total;
  logic [15:0]      bits_done;
  logic [7:0]       tdi_pat;
  logic [7:0]       tms_pat;
  logic [1:0]       pairs_held;
  logic             low_phase;
  logic [7:0]       tdo_acc;
  logic [PIN_W-1:0] pins;

  reply_word_t pending_replies [$];
  reply_word_t head;
  int          mismatches = 0;
  int          words_sent = 0;
  int          idle_mode  = IDLE_NONE;
  int          cur_dly;

  // reply override for pinned directed rows, travels with the word
  logic       dir_pinned;
  logic       dir_txv;
  logic [7:0] dir_byte;

  jtag_command_shift_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int send_idle_pct();
    return (idle_mode == IDLE_SEND) ? 62 : (idle_mode == IDLE_BOTH) ? 15 : 0;
  endfunction

  function automatic int recv_stall_pct();
    return (idle_mode == IDLE_RECV) ? 62 : (idle_mode == IDLE_BOTH) ? 15 : 0;
  endfunction

  // Work out the reply words of one accepted word and queue them.
  task automatic predict_replies(input logic op, input logic [7:0] b, input logic tdo,
                                 input logic pinned, input logic pin_txv,
                                 input logic [7:0] pin_txb);
    logic [7:0]  tx [0:2];
    int          ntx;
    int          nres;
    logic [2:0]  off;
    reply_word_t w;
    ntx = 0;
    if (op == OP_HOST) begin
      case (cmd_ph)
        PH_IDLE: begin
          case (b)
            CMD_MODE:    cmd_ph = PH_MODE;
            CMD_FEAT:    cmd_ph = PH_FEAT1;
            CMD_SHIFT:   cmd_ph = PH_CNT_HI;
            CMD_DELAY:   cmd_ph = PH_DLY_HI;
            CMD_SPEED:   cmd_ph = PH_SPD;
            default: begin
              tx[ntx] = REPLY_UNKNOWN;
              ntx++;
            end
          endcase
        end
        PH_MODE: begin
          pins[PB_TCK]   = 1'b0;
          pins[PB_TDI]   = 1'b0;
          pins[PB_TMS]   = 1'b0;
          pins[PB_TRST]  = 1'b0;
          pins[PB_SRST]  = 1'b0;
          pins[PB_DRIVE] = (b == MODE_DRIVEN);
          cmd_ph = PH_IDLE;
        end
        PH_FEAT1: begin
          arg1   = b;
          cmd_ph = PH_FEAT2;
        end
        PH_FEAT2: begin
          case (arg1)
            FEAT_LED:  pins[PB_LED]  = b[0];
            FEAT_VREG: pins[PB_VREG] = (b != 8'h00);
            FEAT_TRST: pins[PB_TRST] = b[0];
            FEAT_SRST: pins[PB_SRST] = b[0];
            FEAT_PULL: pins[PB_PULL] = (b != 8'h00);
            default: ;
          endcase
          cmd_ph = PH_IDLE;
        end
        PH_DLY_HI: begin
          arg1   = b;
          cmd_ph = PH_DLY_LO;
        end
        PH_DLY_LO: begin
          dly    = {arg1, b};
          cmd_ph = PH_IDLE;
        end
        PH_SPD: begin
          spd_arg       = b;
          pins[PB_FAST] = (b == SPEED_FAST);
          cmd_ph        = PH_HS1;
        end
        PH_HS1: begin
          arg1   = b;
          cmd_ph = PH_HS2;
        end
        PH_HS2: begin
          // broken handshake cancels the speed change
          if (arg1 != HS_FIRST || b != HS_SECOND) begin
            spd_arg       = 8'h00;
            pins[PB_FAST] = 1'b0;
          end
          tx[0]  = CMD_SPEED;
          tx[1]  = spd_arg;
          ntx    = 2;
          cmd_ph = PH_IDLE;
        end
        PH_CNT_HI: begin
          arg1   = b;
          cmd_ph = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          bits_total = {arg1, b};
          tx[0]      = CMD_SHIFT;
          tx[1]      = arg1;
          tx[2]      = b;
          ntx        = 3;
          bits_done  = 16'd0;
          pairs_held = 2'd0;
          low_phase  = 1'b0;
          dly_left   = 16'd0;
          tdo_acc    = 8'h00;
          cmd_ph     = (bits_total == 16'd0) ? PH_IDLE : PH_SHIFT;
        end
        PH_SHIFT: begin
          // a third byte while a full pair is held is dropped
          if (pairs_held == 2'd0) begin
            tdi_pat    = b;
            pairs_held = 2'd1;
          end else if (pairs_held == 2'd1) begin
            tms_pat    = b;
            pairs_held = 2'd2;
          end
        end
        default: cmd_ph = PH_IDLE;
      endcase
    end else if (cmd_ph == PH_SHIFT && pairs_held == 2'd2 && bits_done < bits_total) begin
      off = bits_done[2:0];
      if (!low_phase) begin
        // drive TDI/TMS, pull TCK low, load the hold count
        pins[PB_TDI] = tdi_pat[off];
        pins[PB_TMS] = tms_pat[off];
        pins[PB_TCK] = 1'b0;
        dly_left     = dly;
        low_phase    = 1'b1;
      end else if (dly_left != 16'd0) begin
        dly_left = dly_left - 16'd1;
      end else begin
        // rising edge, sample TDO
        pins[PB_TCK] = 1'b1;
        low_phase    = 1'b0;
        if (tdo)
          tdo_acc[off] = 1'b1;
        bits_done = bits_done + 16'd1;
        if (off == 3'd7 || bits_done == bits_total) begin
          tx[ntx] = tdo_acc;
          ntx++;
          tdo_acc = 8'h00;
        end
        if (off == 3'd7)
          pairs_held = 2'd0;
        if (bits_done == bits_total) begin
          pairs_held = 2'd0;
          cmd_ph     = PH_IDLE;
        end
      end
    end
    nres = (ntx == 0) ? 1 : ntx;
    for (int k = 0; k < nres; k++) begin
      w.txv  = (ntx != 0);
      w.txb  = (ntx == 0) ? 8'h00 : tx[k];
      w.lst  = (k == nres - 1);
      w.pins = pins;
      if (pinned && k == 0) begin
        w.txv = pin_txv;
        w.txb = pin_txb;
      end
      pending_replies.push_back(w);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // input acceptance, result checking and receiver stalls, all on the same edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      predict_replies(in_tuser, in_tdata[7:0], in_tdata[8], dir_pinned, dir_txv, dir_byte);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        $error("result word with nothing expected: tdata 0x%0h", out_tdata);
        mismatches++;
      end else begin
        head = pending_replies.pop_front();
        check_field("tx_valid",       head.txv,            out_tuser);
        check_field("tx_byte",        head.txb,            out_tdata[7:0]);
        check_field("last",           head.lst,            out_tlast);
        check_field("tck_out",        head.pins[PB_TCK],   out_tdata[8]);
        check_field("tdi_out",        head.pins[PB_TDI],   out_tdata[9]);
        check_field("tms_out",        head.pins[PB_TMS],   out_tdata[10]);
        check_field("trst_out",       head.pins[PB_TRST],  out_tdata[11]);
        check_field("srst_out",       head.pins[PB_SRST],  out_tdata[12]);
        check_field("led_out",        head.pins[PB_LED],   out_tdata[13]);
        check_field("power_controls", {head.pins[PB_PULL], head.pins[PB_VREG]},
                    out_tdata[15:14]);
        check_field("pins_driven",    head.pins[PB_DRIVE], out_tdata[16]);
        check_field("fast_serial",    head.pins[PB_FAST],  out_tdata[17]);
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct());
  end

  // Present one word, with random sender gaps, and hold it until taken.
  task automatic send_word(input logic op, input logic [7:0] b, input logic tdo,
                           input logic pinned, input logic pin_txv, input logic [7:0] pin_txb);
    while ($urandom_range(99) < send_idle_pct()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= {7'd0, tdo, b};
    in_tuser   <= op;
    dir_pinned <= pinned;
    dir_txv    <= pin_txv;
    dir_byte   <= pin_txb;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    words_sent++;
  endtask

  task automatic send_host(input logic [7:0] b);
    send_word(OP_HOST, b, 1'($urandom_range(1)), 1'b0, 1'b0, 8'h00);
  endtask

  task automatic send_tick();
    send_word(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, 1'b0, 8'h00);
  endtask

  task automatic set_delay(input logic [15:0] d);
    send_host(CMD_DELAY);
    send_host(d[15:8]);
    send_host(d[7:0]);
    cur_dly = d;
  endtask

  // Full tap shift: header, then pairs and enough ticks to clock each pair out.
  task automatic shift_run(input logic [15:0] nbits);
    int left;
    int nb;
    send_host(CMD_SHIFT);
    send_host(nbits[15:8]);
    send_host(nbits[7:0]);
    left = nbits;
    while (left > 0) begin
      send_host(8'($urandom_range(255)));
      if ($urandom_range(99) < 15)
        send_tick();                      // half a pair: tick does nothing
      send_host(8'($urandom_range(255)));
      if ($urandom_range(99) < 15)
        send_host(8'($urandom_range(255)));   // pair full: byte dropped
      nb = (left > 8) ? 8 : left;
      repeat (nb * (cur_dly + 2))
        send_tick();
      left -= nb;
    end
  endtask

  initial begin : stimulus
    int          base;
    int          pick;
    int          cnt;
    logic [7:0]  b;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 16'd0;
    in_tuser   = OP_HOST;
    out_tready = 1'b0;
    dir_pinned = 1'b0;
    dir_txv    = 1'b0;
    dir_byte   = 8'h00;
    cmd_ph     = PH_IDLE;
    arg1       = 8'h00;
    spd_arg    = 8'h00;
    dly        = 16'd1;
    dly_left   = 16'd0;
    bits_total = 16'd0;
    bits_done  = 16'd0;
    tdi_pat    = 8'h00;
    tms_pat    = 8'h00;
    pairs_held = 2'd0;
    low_phase  = 1'b0;
    tdo_acc    = 8'h00;
    pins       = '0;
    cur_dly    = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < 26; i++)
      send_word(directed_rows[i].op, directed_rows[i].b, directed_rows[i].tdo,
                directed_rows[i].pinned, directed_rows[i].txv, directed_rows[i].txb);
    cur_dly = 0;

    // longer hold across a pair boundary, ending on a partial byte
    set_delay(16'd5);
    shift_run(16'd9);
    set_delay(16'd1);

    // random command sequences, idling scheme changes every stretch
    base = words_sent;
    while (words_sent - base < RAND_WORDS) begin
      idle_mode = ((words_sent - base) / STRETCH) % 4;
      pick = $urandom_range(99);
      if (pick < 40) begin
        cnt = $urandom_range(99);
        if (cnt < 8)
          shift_run(16'd0);
        else if (cnt < 80)
          shift_run(16'($urandom_range(12, 1)));
        else
          shift_run(16'($urandom_range(20, 13)));
      end else if (pick < 55) begin
        send_host(CMD_FEAT);
        case ($urandom_range(5))
          0: send_host(FEAT_LED);
          1: send_host(FEAT_VREG);
          2: send_host(FEAT_TRST);
          3: send_host(FEAT_SRST);
          4: send_host(FEAT_PULL);
          default: send_host(8'($urandom_range(255)));
        endcase
        cnt = $urandom_range(9);
        send_host((cnt < 3) ? 8'h00 : (cnt < 6) ? 8'h01 : 8'($urandom_range(255)));
      end else if (pick < 65) begin
        send_host(CMD_SPEED);
        send_host($urandom_range(1) ? SPEED_FAST : 8'($urandom_range(255)));
        if ($urandom_range(99) < 70) begin
          send_host(HS_FIRST);
          send_host(HS_SECOND);
        end else begin
          send_host($urandom_range(1) ? HS_FIRST : 8'($urandom_range(255)));
          send_host(8'($urandom_range(255)));
        end
      end else if (pick < 75) begin
        set_delay(16'(($urandom_range(99) < 75) ? $urandom_range(3) : $urandom_range(8)));
      end else if (pick < 85) begin
        send_host(CMD_MODE);
        send_host($urandom_range(1) ? MODE_DRIVEN : 8'($urandom_range(255)));
      end else if (pick < 92) begin
        // byte that starts no command
        do
          b = 8'($urandom_range(255));
        while (b == CMD_MODE || b == CMD_FEAT || b == CMD_SHIFT ||
               b == CMD_DELAY || b == CMD_SPEED);
        send_host(b);
      end else begin
        repeat ($urandom_range(4, 1))
          send_tick();
      end
    end

    // drain
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("jtag_command_shift_engine_unit_tb passed");
    else
      $display("jtag_command_shift_engine_unit_tb failed");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("jtag_command_shift_engine_unit_tb failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/jcse_pkg.sv
sv/jcse_core.sv
sv/jtag_command_shift_engine_unit.sv
test/jtag_command_shift_engine_unit_tb.sv
